// ----- design/sliding_window_rate_limit_round_robin_unit_macros.svh -----
// ----------------------------------------------------------------------------
// sliding window rate limiter assertion macros
// implication checks used by the port checker
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_RATE_LIMIT_ROUND_ROBIN_UNIT_MACROS_SVH
`define SLIDING_WINDOW_RATE_LIMIT_ROUND_ROBIN_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define SWRR_ASSERT_SAME(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("swrr same-cycle check failed");

// next-cycle implication, disabled during reset
`define SWRR_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("swrr next-cycle check failed");

`endif

// ----- design/swrr_pkg.sv -----
// ----------------------------------------------------------------------------
// swrr_pkg
// shared types, register indexes and field widths of the rate limiter
// ----------------------------------------------------------------------------
package swrr_pkg;

  // field widths fixed by the interface
  localparam int ARRIVAL_W  = 32;
  localparam int LIMIT_W    = 7;
  localparam int WINDOW_W   = 16;
  localparam int SCOUNT_W   = 5;
  localparam int SRV_OUT_W  = 4;
  localparam int CNT_OUT_W  = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // register indexes
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_LIMIT   = 2'd0;
  localparam cfg_idx_t CFG_WINDOW  = 2'd1;
  localparam cfg_idx_t CFG_SERVERS = 2'd2;

  // register reset values
  localparam logic [LIMIT_W-1:0]  LIMIT_RESET   = 7'd64;
  localparam logic [WINDOW_W-1:0] WINDOW_RESET  = 16'd1000;
  localparam logic [SCOUNT_W-1:0] SERVERS_RESET = 5'd1;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_CHECK = 2'b10
  } state_t;

endpackage

// ----- design/swrr_log_ram.sv -----
// ----------------------------------------------------------------------------
// swrr_log_ram
// timestamp log: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module swrr_log_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- design/swrr_rr_pick.sv -----
// ----------------------------------------------------------------------------
// swrr_rr_pick
// round-robin server choice with clamped server count
// ----------------------------------------------------------------------------
module swrr_rr_pick #(
  parameter int MAX_SERVERS = 16,
  parameter int SW = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1
) (
  input  logic [swrr_pkg::SCOUNT_W-1:0]  server_count,
  input  logic [SW-1:0]                  next_server,
  output logic [swrr_pkg::SRV_OUT_W-1:0] chosen_index,
  output logic [SW-1:0]                  next_server_next
);
  import swrr_pkg::*;

  localparam int MW = $clog2(MAX_SERVERS + 1);
  localparam int CW = (SCOUNT_W > MW) ? SCOUNT_W : MW;

  logic [CW-1:0] count_raw;
  logic [CW-1:0] count_eff;
  logic [CW-1:0] next_ext;
  logic [CW-1:0] chosen;
  logic [CW-1:0] chosen_inc;

  // clamp the count into one to the server maximum
  always_comb begin
    count_raw = CW'(server_count);
    if (count_raw == '0) begin
      count_eff = CW'(1);
    end else if (count_raw > CW'(MAX_SERVERS)) begin
      count_eff = CW'(MAX_SERVERS);
    end else begin
      count_eff = count_raw;
    end
  end

  // stale position after a lowered count falls back to server zero
  always_comb begin
    next_ext   = CW'(next_server);
    chosen     = (next_ext < count_eff) ? next_ext : '0;
    chosen_inc = chosen + CW'(1);
  end

  assign next_server_next = (chosen_inc >= count_eff) ? '0 : chosen_inc[SW-1:0];
  assign chosen_index     = chosen[SRV_OUT_W-1:0];

endmodule

// ----- design/sliding_window_rate_limit_round_robin_unit.sv -----
// ----------------------------------------------------------------------------
// sliding_window_rate_limit_round_robin_unit
// sliding-log rate limiter with round-robin server dispatch
// ----------------------------------------------------------------------------
// input channel: one arrival time per word (in_valid / in_stall); the block
//   forwards the packet while fewer than limit_per_window times are logged,
//   picks the next server and logs the time
// output channel: one word per arrival with forward, server_index and
//   window_count (out_valid / out_stall), held in an output register
// sequence: after accept the word enters the check state, where logged times
//   that have aged out are purged from the head of the log before the result
//   word is loaded into the output register; the purge loop reads one log entry
//   a cycle through the log memory's single read port, and each time is pushed
//   once and popped at most once
// the input stalls while a word is being purged; the next word is accepted
//   while a finished result still waits for the receiver, and a word whose
//   result is ready waits in the purge state until the output register frees
// configuration writes are taken at any time but only meant while idle
// reset clears pointers, occupancy and rotation position and restores the
//   register defaults; the log memory itself is not cleared
// ----------------------------------------------------------------------------
module sliding_window_rate_limit_round_robin_unit #(
  parameter int LOG_DEPTH   = 64,
  parameter int MAX_SERVERS = 16,
  parameter int TIME_WIDTH  = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [swrr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [swrr_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [swrr_pkg::ARRIVAL_W-1:0]  arrival_ms,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            forward,
  output logic [swrr_pkg::SRV_OUT_W-1:0]  server_index,
  output logic [swrr_pkg::CNT_OUT_W-1:0]  window_count
);
  import swrr_pkg::*;

  localparam int PW = $clog2(LOG_DEPTH);
  localparam int OW = $clog2(LOG_DEPTH + 1);
  localparam int LW = (OW > LIMIT_W) ? OW : LIMIT_W;
  localparam int SW = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;

  // configuration registers
  logic [LIMIT_W-1:0]  limit_per_window;
  logic [WINDOW_W-1:0] window_ms;
  logic [SCOUNT_W-1:0] server_count;

  // control state
  state_t          state, state_next;
  logic [PW-1:0]   read_pointer;
  logic [PW-1:0]   write_pointer;
  logic [OW-1:0]   occupancy;
  logic [SW-1:0]   next_server;
  logic            fresh;

  // per-word payload
  logic [TIME_WIDTH-1:0] now_r;
  logic                  fwd_r;
  logic [SRV_OUT_W-1:0]  idx_r;

  logic                         accept;
  logic                         fwd;
  logic [ARRIVAL_W+TIME_WIDTH-1:0] arrival_ext;
  logic [TIME_WIDTH-1:0]        now;
  logic [LW-1:0]                occ_wide;
  logic [PW-1:0]                rp_inc;
  logic [PW-1:0]                wp_inc;
  logic [PW-1:0]                rd_addr;
  logic [TIME_WIDTH-1:0]        rd_data;
  logic [TIME_WIDTH-1:0]        age;
  logic                         head_stale;
  logic                         pop;
  logic                         done;
  logic                         load_out;
  logic [SRV_OUT_W-1:0]         srv_idx;
  logic [SW-1:0]                srv_adv;

  // configuration writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      limit_per_window <= LIMIT_RESET;
      window_ms        <= WINDOW_RESET;
      server_count     <= SERVERS_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_LIMIT:   limit_per_window <= cfg_data[LIMIT_W-1:0];
        CFG_WINDOW:  window_ms        <= cfg_data[WINDOW_W-1:0];
        CFG_SERVERS: server_count     <= cfg_data[SCOUNT_W-1:0];
        default:     ;
      endcase
    end
  end

  // arrival time taken modulo the log time width
  assign arrival_ext = {{TIME_WIDTH{1'b0}}, arrival_ms};
  assign now         = arrival_ext[TIME_WIDTH-1:0];

  // forward while below the limit, the limit saturating at the log depth
  assign occ_wide = LW'(occupancy);
  assign fwd      = (occ_wide < LW'(limit_per_window)) && (occupancy != OW'(LOG_DEPTH));

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != ST_IDLE);

  // pointer wrap
  assign rp_inc = (read_pointer == PW'(LOG_DEPTH - 1)) ? '0 : read_pointer + PW'(1);
  assign wp_inc = (write_pointer == PW'(LOG_DEPTH - 1)) ? '0 : write_pointer + PW'(1);

  swrr_rr_pick #(
    .MAX_SERVERS (MAX_SERVERS),
    .SW          (SW)
  ) u_rr (
    .server_count     (server_count),
    .next_server      (next_server),
    .chosen_index     (srv_idx),
    .next_server_next (srv_adv)
  );

  // head check: an entry only just pushed into an empty log is never stale
  assign age        = now_r - rd_data;
  assign head_stale = !fresh && (occupancy != '0) && (age > TIME_WIDTH'(window_ms));
  assign pop        = (state == ST_CHECK) && head_stale;
  assign done       = (state == ST_CHECK) && !head_stale;
  assign load_out   = done && (!out_valid || !out_stall);

  // read the next head while popping, otherwise keep the current one
  assign rd_addr = pop ? rp_inc : read_pointer;

  swrr_log_ram #(
    .DEPTH (LOG_DEPTH),
    .WIDTH (TIME_WIDTH)
  ) u_log (
    .clk     (clk),
    .wr_en   (accept && fwd),
    .wr_addr (write_pointer),
    .wr_data (now),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (accept) state_next = ST_CHECK;
      ST_CHECK: if (load_out) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // log pointers, occupancy and rotation
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      read_pointer  <= '0;
      write_pointer <= '0;
      occupancy     <= '0;
      next_server   <= '0;
      fresh         <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        fresh <= fwd && (occupancy == '0);
        if (fwd) begin
          write_pointer <= wp_inc;
          occupancy     <= occupancy + OW'(1);
          next_server   <= srv_adv;
        end
      end else if (pop) begin
        read_pointer <= rp_inc;
        occupancy    <= occupancy - OW'(1);
      end
    end
  end

  // word payload captured at accept
  always_ff @(posedge clk) begin
    if (accept) begin
      now_r <= now;
      fwd_r <= fwd;
      idx_r <= fwd ? srv_idx : '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      forward      <= fwd_r;
      server_index <= idx_r;
      window_count <= occ_wide[CNT_OUT_W-1:0];
    end
  end

endmodule

// ----- design/swrr_checker.sv -----
// ----------------------------------------------------------------------------
// swrr_checker
// port-level checks of the rate limiter, bound to the top level
// ----------------------------------------------------------------------------
`include "sliding_window_rate_limit_round_robin_unit_macros.svh"

module swrr_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       forward,
  input logic [3:0] server_index,
  input logic [6:0] window_count
);

  // a stalled result word stays offered
  `SWRR_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid)

  // an accepted word keeps the input busy for the following cycle
  `SWRR_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall)

  // a dropped packet names no server
  `SWRR_ASSERT_SAME(a_drop_no_server, clk, rst, out_valid && !forward, server_index == 4'd0)

  // a forwarded packet is still logged after the purge
  `SWRR_ASSERT_SAME(a_fwd_logged, clk, rst, out_valid && forward, window_count != 7'd0)

endmodule

bind sliding_window_rate_limit_round_robin_unit swrr_checker u_swrr_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .forward      (forward),
  .server_index (server_index),
  .window_count (window_count)
);

// ----- verif/tb_sliding_window_rate_limit_round_robin_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sliding_window_rate_limit_round_robin_unit
// self-checking bench for the sliding-log rate limiter with round-robin
// dispatch: a directed table covers resets, extremes and corner settings,
// then randomised phases with fresh register settings stream arrival times
// shaped around the window; every result word is checked field by field against
// its typed row or a cycle-free predictor of the forward, server and purge decisions
// ----------------------------------------------------------------------------
module tb_sliding_window_rate_limit_round_robin_unit;
  import swrr_pkg::*;

  localparam int LOG_DEPTH      = 64;
  localparam int MAX_SERVERS    = 16;
  localparam int LOG_PTR_W      = $clog2(LOG_DEPTH);
  localparam int RESET_CYCLES   = 11;
  localparam int SETTLE_CYCLES  = 4;
  localparam int TAIL_CYCLES    = 80;
  localparam int HOLD_CYCLES    = 300;
  localparam int RAND_PHASES    = 12;
  localparam int WORDS_PER_PHASE = 160;
  localparam int CYCLE_LIMIT    = 1000000;

  // index with no register behind it
  localparam cfg_idx_t CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic                 fwd;
    logic [SRV_OUT_W-1:0] srv;
    logic [CNT_OUT_W-1:0] cnt;
  } decision_t;

  typedef enum logic {
    ROW_WRITE,
    ROW_WORD
  } row_kind_t;

  typedef struct packed {
    row_kind_t               kind;
    cfg_idx_t                idx;
    logic [CFG_DATA_W-1:0]   data;
    logic [ARRIVAL_W-1:0]    arrival;
    logic                    typed;
    decision_t               want;
  } row_t;

  localparam decision_t NO_WANT = '0;

  // directed table: typed rows carry their decision, the rest use the predictor
  localparam row_t DIRECTED [30] = '{
    // reset defaults: limit 64, window 1000, one server
    '{ROW_WORD,  CFG_LIMIT,   16'h0000, 32'h0000_0000, 1'b1, '{1'b1, 4'd0, 7'd1}},
    '{ROW_WORD,  CFG_LIMIT,   16'h0000, 32'hFFFF_FFFF, 1'b1, '{1'b1, 4'd0, 7'd1}},
    // time wraps past zero, age of six
    '{ROW_WORD,  CFG_LIMIT,   16'h0000, 32'h0000_0005, 1'b1, '{1'b1, 4'd0, 7'd2}},
    '{ROW_WRITE, CFG_SERVERS, 16'h0003, 32'h0000_0000, 1'b0, NO_WANT},
    '{ROW_WORD,  CFG_LIMIT,   16'h0000, 32'h0000_0005, 1'b0, NO_WANT},
    '{ROW_WORD,  CFG_LIMIT,   16'h0000, 32'h0000_0006, 1'b0, NO_WANT},
    '{ROW_WORD,  CFG_LIMIT,   16'h0000, 32'h0000_0007, 1'b0, NO_WANT},
    // log over the new limit: drop, then everything ages out
    '{ROW_WRITE, CFG_LIMIT,   16'h0002, 32'h0000_0000, 1'b0, NO_WANT},
    '{ROW_WORD,  CFG_LIMIT,   16'h0000, 32'h8000_0000, 1'b1, '{1'b0, 4'd0, 7'd0}},
    // zero limit drops on an empty log
    '{ROW_WRITE, CFG_LIMIT,   16'h0000, 32'h0000_0000, 1'b0, NO_WANT},
    '{ROW_WORD,  CFG_LIMIT,   16'h0000, 32'h8000_0001, 1'b1, '{1'b0, 4'd0, 7'd0}},
    // limit above log depth once masked, zero window
    '{ROW_WRITE, CFG_LIMIT,   16'hFFC1, 32'h0000_0000, 1'b0, NO_WANT},
    '{ROW_WRITE, CFG_WINDOW,  16'h0000, 32'h0000_0000, 1'b0, NO_WANT},
    '{ROW_WORD,  CFG_LIMIT,   16'h0000, 32'h0000_0064, 1'b0, NO_WANT},
    '{ROW_WORD,  CFG_LIMIT,   16'h0000, 32'h0000_0064, 1'b0, NO_WANT},
    '{ROW_WORD,  CFG_LIMIT,   16'h0000, 32'h0000_0065, 1'b0, NO_WANT},
    // server count above range, widest window
    '{ROW_WRITE, CFG_SERVERS, 16'hFFFF, 32'h0000_0000, 1'b0, NO_WANT},
    '{ROW_WRITE, CFG_WINDOW,  16'hFFFF, 32'h0000_0000, 1'b0, NO_WANT},
    '{ROW_WORD,  CFG_LIMIT,   16'h0000, 32'h0000_00C8, 1'b0, NO_WANT},
    '{ROW_WORD,  CFG_LIMIT,   16'h0000, 32'h0000_00C9, 1'b0, NO_WANT},
    '{ROW_WORD,  CFG_LIMIT,   16'h0000, 32'h0000_00CA, 1'b0, NO_WANT},
    '{ROW_WORD,  CFG_LIMIT,   16'h0000, 32'h0000_00CB, 1'b0, NO_WANT},
    '{ROW_WORD,  CFG_LIMIT,   16'h0000, 32'h0000_00CC, 1'b0, NO_WANT},
    '{ROW_WORD,  CFG_LIMIT,   16'h0000, 32'h0000_00CD, 1'b0, NO_WANT},
    // rotation left beyond a lowered count
    '{ROW_WRITE, CFG_SERVERS, 16'h0004, 32'h0000_0000, 1'b0, NO_WANT},
    '{ROW_WORD,  CFG_LIMIT,   16'h0000, 32'h0000_00CE, 1'b0, NO_WANT},
    // zero servers counts as one
    '{ROW_WRITE, CFG_SERVERS, 16'h0000, 32'h0000_0000, 1'b0, NO_WANT},
    '{ROW_WORD,  CFG_LIMIT,   16'h0000, 32'h0000_00CF, 1'b0, NO_WANT},
    // write to an unmapped index changes nothing
    '{ROW_WRITE, CFG_UNUSED,  16'hFFFF, 32'h0000_0000, 1'b0, NO_WANT},
    '{ROW_WORD,  CFG_LIMIT,   16'h0000, 32'h0000_00D0, 1'b0, NO_WANT}
  };

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [ARRIVAL_W-1:0]  arrival_ms = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  forward;
  logic [SRV_OUT_W-1:0]  server_index;
  logic [CNT_OUT_W-1:0]  window_count;

  // predictor state and register mirror
  logic [ARRIVAL_W-1:0]  logged_times [LOG_DEPTH];
  logic [LOG_PTR_W-1:0]  log_head = '0;
  logic [LOG_PTR_W-1:0]  log_tail = '0;
  logic [CNT_OUT_W-1:0]  log_fill = '0;
  logic [SRV_OUT_W-1:0]  rotation_pos = '0;
  logic [LIMIT_W-1:0]    mirror_limit = LIMIT_RESET;
  logic [WINDOW_W-1:0]   mirror_window = WINDOW_RESET;
  logic [SCOUNT_W-1:0]   mirror_servers = SERVERS_RESET;

  decision_t pending_decisions [$];
  int        mismatches = 0;
  int        cycle_count = 0;
  bit        no_gaps = 1'b0;
  bit        hold_output = 1'b0;

  sliding_window_rate_limit_round_robin_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .arrival_ms   (arrival_ms),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .forward      (forward),
    .server_index (server_index),
    .window_count (window_count)
  );

  always #4 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic int draw_wait();
    return no_gaps ? 0 : $urandom_range(0, 4);
  endfunction

  // forward/drop decision, log push and purge of aged-out times
  function automatic decision_t rate_limit_decide(input logic [ARRIVAL_W-1:0] now);
    decision_t d;
    int        lim;
    int        nsrv;
    int        chosen;
    lim  = (mirror_limit > LOG_DEPTH) ? LOG_DEPTH : int'(mirror_limit);
    nsrv = (mirror_servers == 0) ? 1 :
           (mirror_servers > MAX_SERVERS) ? MAX_SERVERS : int'(mirror_servers);
    d.fwd = (int'(log_fill) < lim);
    chosen = 0;
    if (d.fwd) begin
      chosen = (int'(rotation_pos) < nsrv) ? int'(rotation_pos) : 0;
      rotation_pos = (chosen + 1 >= nsrv) ? '0 : SRV_OUT_W'(chosen + 1);
      logged_times[log_tail] = now;
      log_tail = log_tail + 1'b1;
      log_fill = log_fill + 1'b1;
    end
    while (log_fill != 0 && (now - logged_times[log_head]) > {16'h0000, mirror_window}) begin
      log_head = log_head + 1'b1;
      log_fill = log_fill - 1'b1;
    end
    d.srv = SRV_OUT_W'(chosen);
    d.cnt = log_fill;
    return d;
  endfunction

  // offer one arrival word and record its decision once taken
  task automatic offer_arrival(input logic [ARRIVAL_W-1:0] t, input logic typed,
                               input decision_t typed_want);
    int        gap;
    decision_t d;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    arrival_ms <= t;
    do @(posedge clk); while (in_stall);
    d = rate_limit_decide(t);
    if (typed) d = typed_want;
    pending_decisions = {pending_decisions, d};
  endtask

  // stop offering and let every pending word come out
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_decisions.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      CFG_LIMIT:   mirror_limit = data[LIMIT_W-1:0];
      CFG_WINDOW:  mirror_window = data[WINDOW_W-1:0];
      CFG_SERVERS: mirror_servers = data[SCOUNT_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // receiver: random stall before each word, one long hold on request
  initial begin : receive_side
    int wait_cycles;
    wait (rst == 1'b0);
    forever begin
      if (hold_output) begin
        wait_cycles = HOLD_CYCLES;
        hold_output = 1'b0;
      end else begin
        wait_cycles = draw_wait();
      end
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // result word checker
  always @(posedge clk) begin : result_check
    decision_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_decisions.size() == 0) begin
        $error("result word with no decision pending");
        mismatches++;
      end else begin
        want = pending_decisions.pop_front();
        if (forward !== want.fwd) begin
          $error("forward: expected %0d, got %0d", want.fwd, forward);
          mismatches++;
        end
        if (server_index !== want.srv) begin
          $error("server_index: expected %0d, got %0d", want.srv, server_index);
          mismatches++;
        end
        if (window_count !== want.cnt) begin
          $error("window_count: expected %0d, got %0d", want.cnt, window_count);
          mismatches++;
        end
      end
    end
  end

  // stimulus: directed table, then randomised phases
  initial begin : send_side
    logic [CFG_DATA_W-1:0] cfg_word;
    logic [ARRIVAL_W-1:0]  clock_ms;
    logic [ARRIVAL_W-1:0]  t;
    int                    lim;
    int                    win;
    int                    srv;
    int                    eff_lim;
    int                    span;
    int                    mode;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].kind == ROW_WRITE) begin
        wait_idle();
        write_register(DIRECTED[i].idx, DIRECTED[i].data);
      end else begin
        offer_arrival(DIRECTED[i].arrival, DIRECTED[i].typed, DIRECTED[i].want);
      end
    end

    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      wait_idle();
      // register settings: extremes first, then random
      case (phase)
        0: begin lim = 1;   win = 1;     srv = 1;  end
        1: begin lim = 64;  win = 65535; srv = 16; end
        2: begin lim = 127; win = 65535; srv = 31; end
        3: begin lim = 0;   win = 0;     srv = 0;  end
        4: begin lim = $urandom_range(1, 64); win = 0; srv = $urandom_range(0, 31); end
        default: begin
          lim = ($urandom_range(0, 7) == 0) ? $urandom_range(65, 127) : $urandom_range(1, 64);
          case ($urandom_range(0, 3))
            0:       win = $urandom_range(1, 16);
            1:       win = $urandom_range(1, 300);
            2:       win = $urandom_range(1, 5000);
            default: win = $urandom_range(0, 65535);
          endcase
          srv = $urandom_range(0, 31);
        end
      endcase
      cfg_word = CFG_DATA_W'($urandom());
      cfg_word[LIMIT_W-1:0] = LIMIT_W'(lim);
      write_register(CFG_LIMIT, cfg_word);
      write_register(CFG_WINDOW, WINDOW_W'(win));
      cfg_word = CFG_DATA_W'($urandom());
      cfg_word[SCOUNT_W-1:0] = SCOUNT_W'(srv);
      write_register(CFG_SERVERS, cfg_word);
      if ($urandom_range(0, 3) == 0) write_register(CFG_UNUSED, CFG_DATA_W'($urandom()));

      no_gaps  = (phase % 4 == 1);
      eff_lim  = (lim > LOG_DEPTH) ? LOG_DEPTH : lim;
      span     = (eff_lim == 0) ? win : win / eff_lim;
      clock_ms = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 3 * win + 64)
                                             : $urandom();

      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        // long receiver hold so the block backs up into its input
        if (phase == 1 && n == 20) hold_output = 1'b1;
        mode = $urandom_range(0, 15);
        if (mode == 0) begin
          t = $urandom();
        end else begin
          if (mode <= 4)       clock_ms = clock_ms;
          else if (mode <= 11) clock_ms = clock_ms + $urandom_range(0, 2 * span + 1);
          else if (mode <= 14) clock_ms = clock_ms + $urandom_range(0, win + 2);
          else                 clock_ms = clock_ms + win + $urandom_range(0, 1);
          t = clock_ms;
        end
        offer_arrival(t, 1'b0, NO_WANT);
      end
    end

    in_valid <= 1'b0;
    while (pending_decisions.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+design
design/swrr_pkg.sv
design/swrr_log_ram.sv
design/swrr_rr_pick.sv
design/sliding_window_rate_limit_round_robin_unit.sv
design/swrr_checker.sv
verif/tb_sliding_window_rate_limit_round_robin_unit.sv
